>>> hw/rtl/fcc_pkg.sv
// shared types, constants and crc helper for the frame checker
`default_nettype none

package fcc_pkg;

  // frame length limits
  localparam int unsigned FCC_MAX_FRAME_BYTES = 255;
  localparam int unsigned FCC_MIN_FRAME_BYTES = 6;

  // crc-16/modbus constants
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // configuration register indexes
  localparam logic [1:0] REG_START_BYTE = 2'd0;
  localparam logic [1:0] REG_DEVICE_ID_FIRST = 2'd1;
  localparam logic [1:0] REG_DEVICE_ID_SECOND = 2'd2;

  // verdict codes, in priority order after none
  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_LENGTH = 3'd1,
    ERR_START  = 3'd2,
    ERR_DEVICE = 3'd3,
    ERR_CRC    = 3'd4
  } error_code_e;

  // register settings seen by the tracker
  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] device_id_first;
    logic [7:0] device_id_second;
  } cfg_t;

  // verdict handed from tracker to result register
  typedef struct packed {
    logic        frame_good;
    error_code_e error_code;
  } verdict_t;

  // fold one byte into the reflected crc, lsb first
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ data[i]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/frame_checker_crc16.sv
// top level of the crc-16 frame checker
//
//  channel | direction | handshake                 | payload
//  in      | input     | in_valid_i / in_stall_o   | data_byte_i, frame_end_i
//  out     | output    | out_valid_o / out_stall_i | frame_good_o, error_code_o
//  cfg     | input     | cfg_we_i                  | cfg_index_i, cfg_data_i
//
// one byte per cycle; the byte two places back is folded into the crc by an
// unrolled eight-bit update in the same cycle a new byte is taken.
// a last byte's verdict is registered and shown in the cycle after it.
// bytes that are not last are taken even while a verdict waits; a last
// byte stalls only while the previous verdict is stalled on the output.
// reset clears the registers, the frame state and the output valid.
`default_nettype none

module frame_checker_crc16 #(
  parameter int unsigned MAX_FRAME_BYTES = fcc_pkg::FCC_MAX_FRAME_BYTES,
  parameter int unsigned MIN_FRAME_BYTES = fcc_pkg::FCC_MIN_FRAME_BYTES
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // configuration writes
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i,
  // byte input
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       frame_end_i,
  // verdict output
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            frame_good_o,
  output logic [2:0]      error_code_o
);
  import fcc_pkg::*;

  cfg_t     cfg_q, cfg_d;
  verdict_t verdict;
  logic     accept;

  // configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_START_BYTE:       cfg_d.start_byte = cfg_data_i;
        REG_DEVICE_ID_FIRST:  cfg_d.device_id_first = cfg_data_i;
        REG_DEVICE_ID_SECOND: cfg_d.device_id_second = cfg_data_i;
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // only a last byte needs room in the output register
  assign in_stall_o = frame_end_i && out_valid_o && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  fcc_frame_track #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
    .MIN_FRAME_BYTES(MIN_FRAME_BYTES)
  ) u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .frame_end_i (frame_end_i),
    .cfg_i       (cfg_q),
    .verdict_o   (verdict)
  );

  fcc_result_reg u_result (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (accept && frame_end_i),
    .verdict_i    (verdict),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .frame_good_o (frame_good_o),
    .error_code_o (error_code_o)
  );

endmodule

`default_nettype wire

>>> hw/rtl/fcc_frame_track.sv
// per-frame state: byte count, header checks, crc and two-byte delay
`default_nettype none

module fcc_frame_track #(
  parameter int unsigned MAX_FRAME_BYTES = fcc_pkg::FCC_MAX_FRAME_BYTES,
  parameter int unsigned MIN_FRAME_BYTES = fcc_pkg::FCC_MIN_FRAME_BYTES
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic [7:0]       data_byte_i,
  input  wire logic             frame_end_i,
  input  wire fcc_pkg::cfg_t    cfg_i,
  output fcc_pkg::verdict_t     verdict_o
);
  import fcc_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_FRAME_BYTES + 2);
  localparam logic [CntW-1:0] CntSat = CntW'(MAX_FRAME_BYTES + 1);
  localparam logic [CntW-1:0] CntCrcFrom = CntW'(3);

  logic [CntW-1:0] cnt_q, cnt_d, cnt_inc;
  logic [15:0]     crc_q, crc_d, crc_upd;
  logic [7:0]      held0_q, held0_d, held1_q, held1_d;
  logic            start_bad_q, start_bad_d, start_bad_upd;
  logic            device_bad_q, device_bad_d, device_bad_upd;
  logic [15:0]     received;
  logic            length_bad;

  // header checks on the first two bytes
  always_comb begin
    start_bad_upd  = start_bad_q;
    device_bad_upd = device_bad_q;
    if (cnt_q == '0) begin
      start_bad_upd = (data_byte_i != cfg_i.start_byte);
    end
    if (cnt_q == CntW'(1)) begin
      device_bad_upd = (data_byte_i != cfg_i.device_id_first) &&
                       (data_byte_i != cfg_i.device_id_second);
    end
  end

  // byte two places back is no longer a trailing crc byte
  assign crc_upd  = (cnt_q >= CntCrcFrom) ? crc_fold(crc_q, held1_q) : crc_q;
  assign cnt_inc  = (cnt_q < CntSat) ? cnt_q + CntW'(1) : cnt_q;
  assign received = {data_byte_i, held0_q};

  // verdict on the last byte
  assign length_bad = (32'(cnt_inc) < 32'(MIN_FRAME_BYTES)) ||
                      (32'(cnt_inc) > 32'(MAX_FRAME_BYTES));

  always_comb begin
    priority if (length_bad) begin
      verdict_o.error_code = ERR_LENGTH;
    end else if (start_bad_upd) begin
      verdict_o.error_code = ERR_START;
    end else if (device_bad_upd) begin
      verdict_o.error_code = ERR_DEVICE;
    end else if (received != crc_upd) begin
      verdict_o.error_code = ERR_CRC;
    end else begin
      verdict_o.error_code = ERR_NONE;
    end
    verdict_o.frame_good = (verdict_o.error_code == ERR_NONE);
  end

  // next state: advance on each item, clear after the last byte
  always_comb begin
    cnt_d        = cnt_q;
    crc_d        = crc_q;
    held0_d      = held0_q;
    held1_d      = held1_q;
    start_bad_d  = start_bad_q;
    device_bad_d = device_bad_q;
    if (accept_i) begin
      if (frame_end_i) begin
        cnt_d        = '0;
        crc_d        = CRC_INIT;
        held0_d      = '0;
        held1_d      = '0;
        start_bad_d  = 1'b0;
        device_bad_d = 1'b0;
      end else begin
        cnt_d        = cnt_inc;
        crc_d        = crc_upd;
        held0_d      = data_byte_i;
        held1_d      = held0_q;
        start_bad_d  = start_bad_upd;
        device_bad_d = device_bad_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      crc_q        <= CRC_INIT;
      held0_q      <= '0;
      held1_q      <= '0;
      start_bad_q  <= 1'b0;
      device_bad_q <= 1'b0;
    end else begin
      cnt_q        <= cnt_d;
      crc_q        <= crc_d;
      held0_q      <= held0_d;
      held1_q      <= held1_d;
      start_bad_q  <= start_bad_d;
      device_bad_q <= device_bad_d;
    end
  end

`ifndef SYNTHESIS
  // count, crc and start flag are back to their frame-start values after a last byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && frame_end_i) |=> (cnt_q == '0 && crc_q == CRC_INIT && !start_bad_q))
    else $error("frame state not cleared after last byte");

  // counter stops at its saturation value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntSat)
    else $error("byte count beyond saturation");

  // crc stays at its initial value until the fourth byte of a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q < CntCrcFrom) |-> (crc_q == CRC_INIT))
    else $error("crc folded too early in the frame");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/fcc_result_reg.sv
// output register holding one verdict until it is taken
`default_nettype none

module fcc_result_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire fcc_pkg::verdict_t verdict_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   frame_good_o,
  output logic [2:0]             error_code_o
);
  import fcc_pkg::*;

  logic     valid_q, valid_d;
  verdict_t res_q, res_d;

  // load a new verdict, or drop the old one once taken
  always_comb begin
    valid_d = valid_q && out_stall_i;
    res_d   = res_q;
    if (load_i) begin
      valid_d = 1'b1;
      res_d   = verdict_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o  = valid_q;
  assign frame_good_o = res_q.frame_good;
  assign error_code_o = res_q.error_code;

`ifndef SYNTHESIS
  // a waiting verdict is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> !(valid_q && out_stall_i))
    else $error("verdict overwritten while stalled");

  // pass flag agrees with the error code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (res_q.frame_good == (res_q.error_code == ERR_NONE)))
    else $error("pass flag and error code disagree");

  // a verdict only appears after a load
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(valid_q) |-> $past(load_i))
    else $error("verdict appeared without a last byte");
`endif

endmodule

`default_nettype wire

>>> verif/testbench.sv
// testbench for the crc-16 frame checker: directed and random frames against a byte-level predictor
`default_nettype none

module testbench;
  import fcc_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS = 56;
  localparam int unsigned NUM_PHASES = 5;
  localparam int unsigned NUM_DIRECTED = 25;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // how a directed row gets its byte
  typedef enum logic [1:0] {
    ROW_LIT,
    ROW_CRC_LO,
    ROW_CRC_HI,
    ROW_CRC_LO_FLIP
  } row_kind_e;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    row_kind_e   kind;
    logic        typed;
    error_code_e code;
  } stim_row_t;

  // directed frames, run with start 0x7e and device ids 0x01 / 0xf7
  stim_row_t directed_rows [NUM_DIRECTED] = '{
    // frame ending on its first byte
    '{8'h7E, 1'b1, ROW_LIT, 1'b1, ERR_LENGTH},
    // shortest good frame
    '{8'h7E, 1'b0, ROW_LIT, 1'b0, ERR_NONE},
    '{8'h01, 1'b0, ROW_LIT, 1'b0, ERR_NONE},
    '{8'h00, 1'b0, ROW_LIT, 1'b0, ERR_NONE},
    '{8'hFF, 1'b0, ROW_LIT, 1'b0, ERR_NONE},
    '{8'h00, 1'b0, ROW_CRC_LO, 1'b0, ERR_NONE},
    '{8'h00, 1'b1, ROW_CRC_HI, 1'b1, ERR_NONE},
    // bad start and bad device: start wins
    '{8'h00, 1'b0, ROW_LIT, 1'b0, ERR_NONE},
    '{8'h02, 1'b0, ROW_LIT, 1'b0, ERR_NONE},
    '{8'h12, 1'b0, ROW_LIT, 1'b0, ERR_NONE},
    '{8'h34, 1'b0, ROW_LIT, 1'b0, ERR_NONE},
    '{8'h00, 1'b0, ROW_CRC_LO, 1'b0, ERR_NONE},
    '{8'h00, 1'b1, ROW_CRC_HI, 1'b1, ERR_START},
    // unknown device
    '{8'h7E, 1'b0, ROW_LIT, 1'b0, ERR_NONE},
    '{8'h02, 1'b0, ROW_LIT, 1'b0, ERR_NONE},
    '{8'h56, 1'b0, ROW_LIT, 1'b0, ERR_NONE},
    '{8'h78, 1'b0, ROW_LIT, 1'b0, ERR_NONE},
    '{8'h00, 1'b0, ROW_CRC_LO, 1'b0, ERR_NONE},
    '{8'h00, 1'b1, ROW_CRC_HI, 1'b1, ERR_DEVICE},
    // second device id, corrupted crc low byte
    '{8'h7E, 1'b0, ROW_LIT, 1'b0, ERR_NONE},
    '{8'hF7, 1'b0, ROW_LIT, 1'b0, ERR_NONE},
    '{8'hAB, 1'b0, ROW_LIT, 1'b0, ERR_NONE},
    '{8'hCD, 1'b0, ROW_LIT, 1'b0, ERR_NONE},
    '{8'h00, 1'b0, ROW_CRC_LO_FLIP, 1'b0, ERR_NONE},
    '{8'h00, 1'b1, ROW_CRC_HI, 1'b1, ERR_CRC}
  };

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = 2'd0;
  logic [7:0] cfg_data_i = 8'h00;
  logic       in_valid_i = 1'b0;
  logic [7:0] data_byte_i = 8'h00;
  logic       frame_end_i = 1'b0;
  logic       out_stall_i = 1'b0;
  wire logic       in_stall_o;
  wire logic       out_valid_o;
  wire logic       frame_good_o;
  wire logic [2:0] error_code_o;

  frame_checker_crc16 uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .frame_end_i  (frame_end_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .frame_good_o (frame_good_o),
    .error_code_o (error_code_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor copy of registers and frame state
  logic [7:0]  mdl_start = 8'h00;
  logic [7:0]  mdl_id_first = 8'h00;
  logic [7:0]  mdl_id_second = 8'h00;
  logic [8:0]  mdl_count = 9'd0;
  logic [15:0] mdl_crc = CRC_INIT;
  logic [7:0]  mdl_held [2] = '{8'h00, 8'h00};
  bit          mdl_start_bad = 1'b0;
  bit          mdl_device_bad = 1'b0;

  verdict_t    pending_verdicts [$];
  logic [7:0]  frame_buf [$];
  bit          idle_on = 1'b1;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left = 0;

  // reflected crc-16, one byte lsb first
  function automatic logic [15:0] modbus_crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  task automatic clear_model_frame();
    mdl_count = 9'd0;
    mdl_crc = CRC_INIT;
    mdl_held[0] = 8'h00;
    mdl_held[1] = 8'h00;
    mdl_start_bad = 1'b0;
    mdl_device_bad = 1'b0;
  endtask

  // advance the frame state by one accepted byte; queue a verdict on the last one
  task automatic predict_frame_byte(input logic [7:0] d, input logic last, input logic typed,
                                    input error_code_e typed_code);
    logic [15:0] received;
    verdict_t    v;
    if (mdl_count == 9'd0) begin
      mdl_start_bad = (d != mdl_start);
    end else if (mdl_count == 9'd1) begin
      mdl_device_bad = (d != mdl_id_first) && (d != mdl_id_second);
    end
    // the byte two places back can no longer be a trailing crc byte
    if (mdl_count >= 9'd3) begin
      mdl_crc = modbus_crc_byte(mdl_crc, mdl_held[1]);
    end
    received = {d, mdl_held[0]};
    mdl_held[1] = mdl_held[0];
    mdl_held[0] = d;
    if (mdl_count < FCC_MAX_FRAME_BYTES + 1) begin
      mdl_count = mdl_count + 9'd1;
    end
    if (last) begin
      if (mdl_count < FCC_MIN_FRAME_BYTES || mdl_count > FCC_MAX_FRAME_BYTES) begin
        v.error_code = ERR_LENGTH;
      end else if (mdl_start_bad) begin
        v.error_code = ERR_START;
      end else if (mdl_device_bad) begin
        v.error_code = ERR_DEVICE;
      end else if (received != mdl_crc) begin
        v.error_code = ERR_CRC;
      end else begin
        v.error_code = ERR_NONE;
      end
      if (typed) begin
        v.error_code = typed_code;
      end
      v.frame_good = (v.error_code == ERR_NONE);
      pending_verdicts.push_back(v);
      clear_model_frame();
    end
  endtask

  // offer one item, with an occasional gap before it
  task automatic send_byte(input logic [7:0] d, input logic last, input logic typed,
                           input error_code_e typed_code);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= d;
    frame_end_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_frame_byte(d, last, typed, typed_code);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_buf.size(); i++) begin
      send_byte(frame_buf[i], i == frame_buf.size() - 1, 1'b0, ERR_NONE);
    end
  endtask

  // register write; the caller lowers the enable after a batch
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_START_BYTE:       mdl_start = val;
      REG_DEVICE_ID_FIRST:  mdl_id_first = val;
      REG_DEVICE_ID_SECOND: mdl_id_second = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [7:0] s, input logic [7:0] a, input logic [7:0] b,
                          input bit poke_unused);
    write_reg(REG_START_BYTE, s);
    write_reg(REG_DEVICE_ID_FIRST, a);
    write_reg(REG_DEVICE_ID_SECOND, b);
    if (poke_unused) begin
      write_reg(REG_UNUSED, 8'($urandom));
    end
    cfg_we_i <= 1'b0;
  endtask

  // drain every verdict, then let the output stage settle
  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // frame with start, device id, payload and trailing crc, mostly well-formed
  task automatic build_wellformed(input int unsigned len, input bit corrupt);
    logic [15:0] crc;
    int unsigned pick;
    frame_buf.delete();
    frame_buf.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : mdl_start);
    pick = $urandom_range(0, 19);
    frame_buf.push_back(pick < 9 ? mdl_id_first : (pick < 18 ? mdl_id_second : 8'($urandom)));
    while (frame_buf.size() < len - 2) frame_buf.push_back(8'($urandom));
    crc = CRC_INIT;
    for (int i = 1; i < len - 2; i++) begin
      crc = modbus_crc_byte(crc, frame_buf[i]);
    end
    if (corrupt) begin
      crc = crc ^ (16'd1 << $urandom_range(0, 15));
    end
    frame_buf.push_back(crc[7:0]);
    frame_buf.push_back(crc[15:8]);
  endtask

  task automatic build_noise(input int unsigned len, input bit keep_start);
    frame_buf.delete();
    repeat (len) frame_buf.push_back(8'($urandom));
    if (keep_start) begin
      frame_buf[0] = mdl_start;
    end
  endtask

  task automatic run_random_phase(input bit with_long);
    int unsigned sent;
    int unsigned r;
    sent = 0;
    // one frame running past the point where the byte count saturates
    if (with_long) begin
      build_wellformed(FCC_MAX_FRAME_BYTES + 2, 1'b0);
      send_frame();
      sent += frame_buf.size();
    end
    while (sent < PHASE_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 72) begin
        build_wellformed(($urandom_range(0, 7) == 0) ? $urandom_range(17, 40)
                                                     : $urandom_range(6, 16),
                         $urandom_range(0, 9) == 0);
      end else if (r < 86) begin
        build_noise($urandom_range(1, 5), 1'b1);
      end else begin
        build_noise($urandom_range(1, 24), 1'b0);
      end
      send_frame();
      sent += frame_buf.size();
    end
  endtask

  // verdict checking and output stall bursts
  always @(posedge clk_i) begin
    verdict_t exp_v;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected item: expected none, actual good %0d code %0d",
                 $time, frame_good_o, error_code_o);
        mismatch_count++;
      end else begin
        exp_v = pending_verdicts.pop_front();
        if (frame_good_o !== exp_v.frame_good) begin
          $display("%0t: frame_good expected %0d actual %0d",
                   $time, exp_v.frame_good, frame_good_o);
          mismatch_count++;
        end
        if (error_code_o !== exp_v.error_code) begin
          $display("%0t: error_code expected %0d actual %0d",
                   $time, exp_v.error_code, error_code_o);
          mismatch_count++;
        end
      end
    end
    if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 17);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // watchdog on handshake activity
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    logic [15:0] dir_crc;
    logic [7:0]  b;
    dir_crc = CRC_INIT;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed frames
    set_regs(8'h7E, 8'h01, 8'hF7, 1'b0);
    frame_buf.delete();
    for (int n = 0; n < NUM_DIRECTED; n++) begin
      case (directed_rows[n].kind)
        ROW_CRC_LO, ROW_CRC_LO_FLIP: begin
          dir_crc = CRC_INIT;
          for (int i = 1; i < frame_buf.size(); i++) begin
            dir_crc = modbus_crc_byte(dir_crc, frame_buf[i]);
          end
          b = dir_crc[7:0] ^ ((directed_rows[n].kind == ROW_CRC_LO_FLIP) ? 8'h01 : 8'h00);
        end
        ROW_CRC_HI: b = dir_crc[15:8];
        default:    b = directed_rows[n].data;
      endcase
      if (directed_rows[n].last) begin
        frame_buf.delete();
      end else begin
        frame_buf.push_back(b);
      end
      send_byte(b, directed_rows[n].last, directed_rows[n].typed, directed_rows[n].code);
    end

    // random phases over several register settings; no idling in the last one
    for (int p = 0; p < NUM_PHASES; p++) begin
      quiesce();
      case (p)
        0:       set_regs(8'h00, 8'h00, 8'hFF, 1'b0);
        1:       set_regs(8'hFF, 8'hFF, 8'h00, 1'b0);
        3:       set_regs(8'h80, 8'hFF, 8'h7F, 1'b0);
        default: set_regs(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
      endcase
      idle_on = (p != NUM_PHASES - 1);
      run_random_phase(p == 1);
    end

    quiesce();
    if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
